FILE: rtl/core/b64d_pkg.sv
// b64d_pkg: shared types, codes and the alphabet lookup for the base64 decoder.
// Used by every module in rtl/core; depends on nothing else.

package b64d_pkg;

	// ASCII codes of the characters with a role of their own
	localparam logic [7:0] CHAR_PAD   = 8'h3D; // '='
	localparam logic [7:0] CHAR_PLUS  = 8'h2B; // '+'
	localparam logic [7:0] CHAR_SLASH = 8'h2F; // '/'
	localparam logic [7:0] CHAR_UA    = 8'h41; // 'A'
	localparam logic [7:0] CHAR_UZ    = 8'h5A; // 'Z'
	localparam logic [7:0] CHAR_LA    = 8'h61; // 'a'
	localparam logic [7:0] CHAR_LZ    = 8'h7A; // 'z'
	localparam logic [7:0] CHAR_D0    = 8'h30; // '0'
	localparam logic [7:0] CHAR_D9    = 8'h39; // '9'

	localparam logic [5:0] SEXTET_PLUS  = 6'd62;
	localparam logic [5:0] SEXTET_SLASH = 6'd63;

	typedef enum logic [1:0] {
		ST_RUN = 2'd0,
		ST_PAD = 2'd1,
		ST_BAD = 2'd2
	} status_t;

	// One decoded record: what one input item turns into.
	// bytes are packed first byte highest; unused bytes are zero.
	typedef struct packed {
		logic [23:0] bytes;
		logic [1:0]  count;  // number of bytes, 0 for a bare end mark
		logic        fin;    // record comes from a final character
		status_t     status;
	} rec_t;

	// Lookup: {valid, sextet}
	function automatic logic [6:0] sextet_of(input logic [7:0] ch);
		logic [7:0] d;
		d = 8'd0;
		if (ch >= CHAR_UA && ch <= CHAR_UZ) begin
			d = ch - CHAR_UA;
			return {1'b1, d[5:0]};
		end else if (ch >= CHAR_LA && ch <= CHAR_LZ) begin
			d = ch - CHAR_LA + 8'd26;
			return {1'b1, d[5:0]};
		end else if (ch >= CHAR_D0 && ch <= CHAR_D9) begin
			d = ch - CHAR_D0 + 8'd52;
			return {1'b1, d[5:0]};
		end else if (ch == CHAR_PLUS) begin
			return {1'b1, SEXTET_PLUS};
		end else if (ch == CHAR_SLASH) begin
			return {1'b1, SEXTET_SLASH};
		end
		return {1'b0, d[5:0]};
	endfunction

endpackage

FILE: rtl/core/b64d_front.sv
// b64d_front: accepts characters, keeps the group state and turns each item
// that yields bytes or is final into one record for the queue. Depends on b64d_pkg.

module b64d_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  logic [7:0]     char_in,
	input  logic           is_final,
	input  logic           q_full,
	output logic           push,
	output b64d_pkg::rec_t rec
);

	logic [17:0]        accum_q, accum_d;
	logic [1:0]         pos_q, pos_d;
	b64d_pkg::status_t  stop_q, stop_d;
	logic [6:0]         lut;
	logic [5:0]         sx;
	logic [17:0]        acc_sh;
	logic [1:0]         pos_inc;
	logic               take;

	assign item_stall = q_full;
	assign take       = item_valid && !q_full;
	assign lut        = b64d_pkg::sextet_of(char_in);
	assign sx         = lut[5:0];
	assign acc_sh     = {accum_q[11:0], sx};
	assign pos_inc    = pos_q + 2'd1;

	always_comb begin
		accum_d    = accum_q;
		pos_d      = pos_q;
		stop_d     = stop_q;
		rec.bytes  = 24'd0;
		rec.count  = 2'd0;
		if (stop_q == b64d_pkg::ST_RUN) begin
			if (char_in == b64d_pkg::CHAR_PAD) begin
				if (pos_q == 2'd2) begin
					rec.bytes = {accum_q[11:4], 16'd0};
					rec.count = 2'd1;
				end else if (pos_q == 2'd3) begin
					rec.bytes = {accum_q[17:10], accum_q[9:2], 8'd0};
					rec.count = 2'd2;
				end
				stop_d = b64d_pkg::ST_PAD;
			end else if (!lut[6]) begin
				stop_d = b64d_pkg::ST_BAD;
			end else if (pos_q == 2'd3) begin
				// complete the group
				rec.bytes = {accum_q, sx};
				rec.count = 2'd3;
				accum_d   = 18'd0;
				pos_d     = 2'd0;
			end else begin
				accum_d = acc_sh;
				pos_d   = pos_inc;
				if (is_final) begin
					// flush the partial group
					unique case (pos_inc)
						2'd1: begin
							rec.bytes = {sx, 2'b00, 16'd0};
							rec.count = 2'd1;
						end
						2'd2: begin
							rec.bytes = {acc_sh[11:4], 16'd0};
							rec.count = 2'd1;
						end
						2'd3: begin
							rec.bytes = {acc_sh[17:10], acc_sh[9:2], 8'd0};
							rec.count = 2'd2;
						end
						default: begin
							rec.bytes = 24'd0;
							rec.count = 2'd0;
						end
					endcase
				end
			end
		end
		rec.fin    = is_final;
		rec.status = stop_d;
		push       = take && (is_final || rec.count != 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= 18'd0;
			pos_q   <= 2'd0;
			stop_q  <= b64d_pkg::ST_RUN;
		end else if (take) begin
			if (is_final) begin
				// start a new string
				accum_q <= 18'd0;
				pos_q   <= 2'd0;
				stop_q  <= b64d_pkg::ST_RUN;
			end else begin
				accum_q <= accum_d;
				pos_q   <= pos_d;
				stop_q  <= stop_d;
			end
		end
	end

endmodule

FILE: rtl/core/b64d_queue.sv
// b64d_queue: short register queue of decoded records between front and back.
// Depends on b64d_pkg.

module b64d_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  b64d_pkg::rec_t wr_rec,
	input  logic           pop,
	output b64d_pkg::rec_t rd_rec,
	output logic           full,
	output logic           empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	b64d_pkg::rec_t mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = cnt_q == FULL_CNT;
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_rec  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

FILE: rtl/core/b64d_back.sv
// b64d_back: walks the record at the queue head and sends one result per
// cycle while result_stall is low, through a registered output. Depends on b64d_pkg.

module b64d_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  b64d_pkg::rec_t head,
	output logic           pop,
	output logic           result_valid,
	input  logic           result_stall,
	output logic [7:0]     byte_out,
	output logic           has_byte,
	output logic           end_mark,
	output logic [1:0]     status
);

	logic [1:0] idx_q;
	logic [1:0] last_idx;
	logic       last;
	logic       load;
	logic [7:0] sel_byte;

	assign last_idx = (head.count == 2'd0) ? 2'd0 : head.count - 2'd1;
	assign last     = idx_q == last_idx;
	assign load     = !q_empty && (!result_valid || !result_stall);
	assign pop      = load && last;

	always_comb begin
		case (idx_q)
			2'd0:    sel_byte = head.bytes[23:16];
			2'd1:    sel_byte = head.bytes[15:8];
			2'd2:    sel_byte = head.bytes[7:0];
			default: sel_byte = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
			idx_q        <= 2'd0;
		end else begin
			if (load) begin
				result_valid <= 1'b1;
				idx_q        <= last ? 2'd0 : idx_q + 2'd1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_out <= sel_byte;
			has_byte <= head.count != 2'd0;
			end_mark <= head.fin && last;
			status   <= head.status;
		end
	end

endmodule

FILE: rtl/core/base64_decoder.sv
// base64_decoder: top level of the streaming base64 decoder.
// Instantiates b64d_front, b64d_queue and b64d_back; uses b64d_pkg.
//
// channel  | handshake                   | payload
// ---------+-----------------------------+--------------------------------------
// item     | item_valid / item_stall     | char_in[7:0], is_final
// result   | result_valid / result_stall | byte_out[7:0], has_byte, end_mark,
//          |                             | status[1:0]
//
// One character is accepted per cycle whenever the record queue has room;
// the front decodes it and builds its record in the same cycle, from its registered group state.
// The back sends one result per cycle while result_stall is low; a character that closes a group
// yields three results, a pad or flush up to two, a bare end mark one,
// others none.
// After its character is taken, a result passes first through the queue and
// then through the output register.
// Reset (arst_n low) empties the queue, drops the output and clears the
// group state. item_stall rises only while the queue is full.

module base64_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [7:0] char_in,
	input  logic       is_final,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] byte_out,
	output logic       has_byte,
	output logic       end_mark,
	output logic [1:0] status
);

	b64d_pkg::rec_t wr_rec;
	b64d_pkg::rec_t head;
	logic           push;
	logic           pop;
	logic           q_full;
	logic           q_empty;

	// Front: decode characters and hold the group state; stall on a full queue.
	b64d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.char_in    (char_in),
		.is_final   (is_final),
		.q_full     (q_full),
		.push       (push),
		.rec        (wr_rec)
	);

	// Queue: decouple decoding from result delivery.
	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_rec (wr_rec),
		.pop    (pop),
		.rd_rec (head),
		.full   (q_full),
		.empty  (q_empty)
	);

	// Back: split each record into results and hold them under result_stall.
	b64d_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.byte_out     (byte_out),
		.has_byte     (has_byte),
		.end_mark     (end_mark),
		.status       (status)
	);

endmodule

FILE: sim/base64_decoder_tb.sv
// base64_decoder_tb: self-checking testbench for the streaming base64 decoder.
// Needs b64d_pkg and base64_decoder from rtl/core; reads no files.
`timescale 1ns / 1ps

module base64_decoder_tb;

	localparam int HOLD_CYCLES = 60;    // long receiver hold-off in the squeeze phase
	localparam int WATCHDOG_LIMIT = 2000; // cycles with no item moving on either side
	localparam int DRAIN_CYCLES = 10;   // drain wait before the final check, as results trail their character

	typedef struct {
		logic [7:0] ch;
		logic       fin;
	} char_item_t;

	typedef struct {
		logic [7:0]        data;
		logic              has;
		logic              last;
		b64d_pkg::status_t st;
	} decoded_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_stall;
	logic [7:0] char_in = 8'h00;
	logic       is_final = 1'b0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	logic [7:0] byte_out;
	logic       has_byte;
	logic       end_mark;
	logic [1:0] status;

	// characters waiting for the driver, and decoded results waiting for the monitor
	char_item_t chars_to_send[$];
	decoded_t   decoded_due[$];

	// decoder state as the checker sees it
	logic [17:0]       grp_acc = '0;
	logic [1:0]        grp_pos = '0;
	b64d_pkg::status_t grp_stop = b64d_pkg::ST_RUN;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_req = 0;
	int mismatches = 0;
	int chars_accepted = 0;
	int results_checked = 0;
	int strings_closed = 0;
	int pad_stops = 0;
	int bad_stops = 0;
	int idle_cycles = 0;

	base64_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.char_in      (char_in),
		.is_final     (is_final),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.byte_out     (byte_out),
		.has_byte     (has_byte),
		.end_mark     (end_mark),
		.status       (status)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// {valid, sextet} for one character of the standard alphabet
	function automatic logic [6:0] alpha_value(input logic [7:0] ch);
		if (ch >= b64d_pkg::CHAR_UA && ch <= b64d_pkg::CHAR_UZ)
			return {1'b1, 6'(ch - b64d_pkg::CHAR_UA)};
		if (ch >= b64d_pkg::CHAR_LA && ch <= b64d_pkg::CHAR_LZ)
			return {1'b1, 6'(ch - b64d_pkg::CHAR_LA + 8'd26)};
		if (ch >= b64d_pkg::CHAR_D0 && ch <= b64d_pkg::CHAR_D9)
			return {1'b1, 6'(ch - b64d_pkg::CHAR_D0 + 8'd52)};
		if (ch == b64d_pkg::CHAR_PLUS) return {1'b1, b64d_pkg::SEXTET_PLUS};
		if (ch == b64d_pkg::CHAR_SLASH) return {1'b1, b64d_pkg::SEXTET_SLASH};
		return 7'd0;
	endfunction

	// Decode one accepted character and queue the results it must produce.
	task automatic predict_char(input logic [7:0] ch, input logic fin);
		logic [7:0]  out_b [0:2];
		logic [6:0]  look;
		logic [23:0] whole;
		decoded_t    res;
		int          n;
		n = 0;
		look = alpha_value(ch);
		if (grp_stop == b64d_pkg::ST_RUN) begin
			if (ch == b64d_pkg::CHAR_PAD) begin
				// padding releases whatever the held sextets complete, then stops
				if (grp_pos == 2'd2) begin
					out_b[n] = grp_acc[11:4];
					n++;
				end else if (grp_pos == 2'd3) begin
					out_b[n] = grp_acc[17:10];
					n++;
					out_b[n] = grp_acc[9:2];
					n++;
				end
				grp_stop = b64d_pkg::ST_PAD;
				pad_stops++;
			end else if (!look[6]) begin
				// invalid character: drop the partial group
				grp_stop = b64d_pkg::ST_BAD;
				bad_stops++;
			end else if (grp_pos == 2'd3) begin
				whole = {grp_acc, look[5:0]};
				out_b[0] = whole[23:16];
				out_b[1] = whole[15:8];
				out_b[2] = whole[7:0];
				n = 3;
				grp_acc = '0;
				grp_pos = '0;
			end else begin
				grp_acc = {grp_acc[11:0], look[5:0]};
				grp_pos = grp_pos + 2'd1;
				if (fin) begin
					// flush the partial group; a lone sextet pads with zero bits
					if (grp_pos == 2'd1) begin
						out_b[n] = {grp_acc[5:0], 2'b00};
						n++;
					end else if (grp_pos == 2'd2) begin
						out_b[n] = grp_acc[11:4];
						n++;
					end else if (grp_pos == 2'd3) begin
						out_b[n] = grp_acc[17:10];
						n++;
						out_b[n] = grp_acc[9:2];
						n++;
					end
				end
			end
		end
		for (int k = 0; k < n; k++) begin
			res.data = out_b[k];
			res.has = 1'b1;
			res.last = fin && (k == n - 1);
			res.st = grp_stop;
			decoded_due.push_back(res);
		end
		if (fin && n == 0) begin
			// nothing to emit: a bare end mark carries the status
			res.data = 8'h00;
			res.has = 1'b0;
			res.last = 1'b1;
			res.st = grp_stop;
			decoded_due.push_back(res);
		end
		if (fin) begin
			grp_acc = '0;
			grp_pos = '0;
			grp_stop = b64d_pkg::ST_RUN;
			strings_closed++;
		end
	endtask

	function automatic logic [7:0] pick_alpha();
		int r;
		r = $urandom_range(63);
		if (r < 26) return b64d_pkg::CHAR_UA + 8'(r);
		if (r < 52) return b64d_pkg::CHAR_LA + 8'(r - 26);
		if (r < 62) return b64d_pkg::CHAR_D0 + 8'(r - 52);
		return (r == 62) ? b64d_pkg::CHAR_PLUS : b64d_pkg::CHAR_SLASH;
	endfunction

	function automatic logic [7:0] pick_invalid();
		logic [7:0] c;
		logic [6:0] look;
		do begin
			c = 8'($urandom_range(255));
			look = alpha_value(c);
		end while (look[6] || c == b64d_pkg::CHAR_PAD);
		return c;
	endfunction

	task automatic push_char(input logic [7:0] c, input logic fin);
		char_item_t it;
		it.ch = c;
		it.fin = fin;
		chars_to_send.push_back(it);
	endtask

	task automatic push_text(input string s, input logic fin);
		for (int i = 0; i < s.len(); i++) push_char(s[i], fin && (i == s.len() - 1));
	endtask

	// One random string: mostly well-formed with random content, some broken, some noise.
	task automatic gen_string();
		logic [7:0] txt[$];
		int         kind;
		int         n;
		logic       fin;
		kind = $urandom_range(99);
		fin = 1'b1;
		repeat ($urandom_range(2) * 4) txt.push_back(pick_alpha());
		if (kind < 40) begin
			// clean end or a flushed partial group
			repeat ($urandom_range(3)) txt.push_back(pick_alpha());
		end else if (kind < 65) begin
			// proper padding in the third or fourth place
			n = $urandom_range(2, 3);
			repeat (n) txt.push_back(pick_alpha());
			repeat (4 - n) txt.push_back(b64d_pkg::CHAR_PAD);
		end else if (kind < 80) begin
			// invalid character somewhere in a group, then trailing junk
			repeat ($urandom_range(3)) txt.push_back(pick_alpha());
			txt.push_back(pick_invalid());
			repeat ($urandom_range(2)) txt.push_back(8'($urandom_range(255)));
		end else if (kind < 90) begin
			// padding too early in the group
			repeat ($urandom_range(1)) txt.push_back(pick_alpha());
			txt.push_back(b64d_pkg::CHAR_PAD);
			repeat ($urandom_range(2)) txt.push_back(8'($urandom_range(255)));
		end else begin
			// raw noise; sometimes leave the string open into the next one
			repeat ($urandom_range(1, 4)) txt.push_back(8'($urandom_range(255)));
			fin = 1'($urandom_range(1));
		end
		if (txt.size() == 0) txt.push_back(pick_alpha());
		foreach (txt[i]) push_char(txt[i], fin && (i == txt.size() - 1));
	endtask

	// Queue a phase worth of strings, then wait until every character is sent and every result is back.
	task automatic run_phase(input int send_pct, input int stall_pct, input int n_chars,
			input logic squeeze);
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		while (chars_to_send.size() < n_chars) gen_string();
		if (squeeze) hold_req++;
		@(negedge clk);
		while (chars_to_send.size() != 0 || item_valid || decoded_due.size() != 0)
			@(negedge clk);
		// a stop without a final produces nothing, so let the back end settle too
		repeat (4) @(negedge clk);
	endtask

	// Driver: advance to the next character once the current one is taken.
	always @(posedge clk or negedge arst_n) begin
		char_item_t nxt;
		logic       taken;
		if (!arst_n) begin
			item_valid <= 1'b0;
			char_in <= 8'h00;
			is_final <= 1'b0;
		end else begin
			taken = item_valid && !item_stall;
			if (taken) begin
				predict_char(char_in, is_final);
				chars_accepted++;
			end
			// hold a stalled item as it is; otherwise offer the next one or idle
			if (!item_valid || taken) begin
				if (chars_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = chars_to_send.pop_front();
					item_valid <= 1'b1;
					char_in <= nxt.ch;
					is_final <= nxt.fin;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall: random, or a long counted hold-off when one is requested.
	always @(posedge clk or negedge arst_n) begin
		int hold_left;
		int hold_seen;
		if (!arst_n) begin
			result_stall <= 1'b0;
			hold_left = 0;
			hold_seen = 0;
		end else begin
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Monitor: compare each taken result with the oldest expected one.
	always @(posedge clk) begin
		decoded_t want;
		if (arst_n && result_valid && !result_stall) begin
			results_checked++;
			if (decoded_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none,", $realtime,
					" got byte %02h has %0d end %0d status %0d",
					byte_out, has_byte, end_mark, status);
			end else begin
				want = decoded_due.pop_front();
				if (has_byte !== want.has || end_mark !== want.last ||
						status !== want.st || byte_out !== want.data) begin
					mismatches++;
					$display("%0t: result mismatch, expected byte %02h has %0d end %0d",
						$realtime, want.data, want.has, want.last,
						" status %0d, got byte %02h has %0d end %0d status %0d",
						want.st, byte_out, has_byte, end_mark, status);
				end
			end
		end
	end

	// Watchdog: end the run if nothing moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no handshake for %0d cycles, %0d results outstanding",
					$realtime, idle_cycles, decoded_due.size());
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: full group then a one-sextet flush
		push_text("TWFu/", 1'b1);
		// pad in the third place, then a final character after the stop
		push_text("TQ=z", 1'b1);
		// pad in the fourth place on the final character
		push_text("TWE=", 1'b1);
		// pad in the first and in the second place
		push_text("=", 1'b1);
		push_text("Q=", 1'b1);
		// invalid characters at both ends of the byte range
		push_char(8'h00, 1'b1);
		push_text("+/", 1'b0);
		push_char(8'hFF, 1'b1);
		// two- and three-sextet flushes
		push_text("+/", 1'b1);
		push_text("09a", 1'b1);
		run_phase(0, 0, 0, 1'b0);

		// random strings under each idling mix
		run_phase(0, 0, 25, 1'b0);
		run_phase(56, 0, 25, 1'b0);
		run_phase(0, 56, 25, 1'b0);
		run_phase(29, 29, 25, 1'b0);
		// receiver holds off while the sender keeps offering, so the input stalls
		run_phase(0, 0, 25, 1'b1);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (decoded_due.size() != 0) begin
			mismatches++;
			$display("%0t: %0d expected results never arrived", $realtime,
				decoded_due.size());
		end
		$display("Covered %0d characters in %0d closed strings;", chars_accepted,
			strings_closed, " %0d results checked, %0d mismatches.",
			results_checked, mismatches);
		$display("Stops seen: %0d by padding, %0d by invalid characters,", pad_stops,
			bad_stops, " across six idling phases.");
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
